/* sv/checkerboard_memory_test_sequencer_defines.svh */
// Assertion macros for the checkerboard memory test sequencer.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef CHECKERBOARD_MEMORY_TEST_SEQUENCER_DEFINES_SVH
`define CHECKERBOARD_MEMORY_TEST_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CBMT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cbmt check failed");

// next-cycle implication
`define CBMT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cbmt check failed");

`else

`define CBMT_ASSERT_NOW(label, clk, rst, ante, cons)
`define CBMT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* sv/cbmt_pkg.sv */
// Shared types, codes and helpers for the checkerboard memory test sequencer.
// No dependencies; used by cbmt_csr, cbmt_step and the top level.
`timescale 1ns / 1ps

package cbmt_pkg;

   localparam int INDEX_BITS = 26;
   localparam int ADDR_BITS  = 30;
   localparam int DATA_BITS  = 32;
   localparam int WC_BITS    = 27;
   localparam int CNT_BITS   = (INDEX_BITS + 1 > WC_BITS) ? INDEX_BITS + 1 : WC_BITS;
   localparam int PADDR_BITS = 5;
   localparam int REG_SEL_BITS = 3;

   localparam logic [INDEX_BITS-1:0] IDX_ONE = INDEX_BITS'(1);

   // operation codes
   localparam logic [2:0] OP_WRITE = 3'd0;
   localparam logic [2:0] OP_READ  = 3'd1;
   localparam logic [2:0] OP_PASS  = 3'd2;
   localparam logic [2:0] OP_FAIL  = 3'd3;
   localparam logic [2:0] OP_IDLE  = 3'd4;

   // request kinds
   localparam logic KIND_START   = 1'b0;
   localparam logic KIND_ADVANCE = 1'b1;

   // pass codes
   localparam logic [1:0] PASS_FILL   = 2'd0;
   localparam logic [1:0] PASS_VERIFY = 2'd1;
   localparam logic [1:0] PASS_FINAL  = 2'd2;
   localparam logic [1:0] PASS_DONE   = 2'd3;

   // register indexes
   localparam logic [REG_SEL_BITS-1:0] REG_BASE_WORD     = 3'd0;
   localparam logic [REG_SEL_BITS-1:0] REG_WORD_COUNT    = 3'd1;
   localparam logic [REG_SEL_BITS-1:0] REG_PATTERN_ONE   = 3'd2;
   localparam logic [REG_SEL_BITS-1:0] REG_PATTERN_TWO   = 3'd3;
   localparam logic [REG_SEL_BITS-1:0] REG_PATTERN_THREE = 3'd4;
   localparam logic [REG_SEL_BITS-1:0] REG_PATTERNS_USED = 3'd5;

   localparam logic [WC_BITS-1:0]   WORD_COUNT_RST    = WC_BITS'(2);
   localparam logic [DATA_BITS-1:0] PATTERN_ONE_RST   = 32'hAAAA_AAAA;
   localparam logic [DATA_BITS-1:0] PATTERN_TWO_RST   = 32'h0000_FFFF;
   localparam logic [DATA_BITS-1:0] PATTERN_THREE_RST = 32'hAAAA_5555;
   localparam logic [1:0]           PATTERNS_USED_RST = 2'd3;

   typedef struct packed {
      logic [ADDR_BITS-1:0] base_word;
      logic [WC_BITS-1:0]   word_count;
      logic [DATA_BITS-1:0] pattern_one;
      logic [DATA_BITS-1:0] pattern_two;
      logic [DATA_BITS-1:0] pattern_three;
      logic [1:0]           patterns_in_use;
   } cfg_type;

   typedef struct packed {
      logic                 kind;
      logic [DATA_BITS-1:0] read_data;
   } req_type;

   typedef struct packed {
      logic [2:0]           op;
      logic [ADDR_BITS-1:0] address;
      logic [DATA_BITS-1:0] write_data;
      logic [DATA_BITS-1:0] fail_expected;
      logic [DATA_BITS-1:0] fail_actual;
      logic [1:0]           fail_pattern;
   } rsp_type;

   typedef struct packed {
      logic                  running;
      logic [1:0]            pass_number;
      logic [1:0]            pattern_index;
      logic [INDEX_BITS-1:0] word_index;
      logic                  compare_pending;
      logic [INDEX_BITS-1:0] compare_index;
      logic [DATA_BITS-1:0]  compare_value;
   } state_type;

   localparam state_type STATE_RST = '0;

   localparam state_type STATE_START = '{
      running:         1'b1,
      pass_number:     PASS_FILL,
      pattern_index:   2'd0,
      word_index:      '0,
      compare_pending: 1'b0,
      compare_index:   '0,
      compare_value:   '0
   };

   function automatic logic [DATA_BITS-1:0] first_value(
      input cfg_type cfg, input logic [1:0] pat_idx, input logic odd);
      logic [DATA_BITS-1:0] pat;
      if (pat_idx == 2'd0) begin
         pat = cfg.pattern_one;
      end else if (pat_idx == 2'd1) begin
         pat = cfg.pattern_two;
      end else begin
         pat = cfg.pattern_three;
      end
      return odd ? ~pat : pat;
   endfunction

   function automatic logic [ADDR_BITS-1:0] word_addr(
      input logic [ADDR_BITS-1:0] base, input logic [INDEX_BITS-1:0] idx);
      return base + ADDR_BITS'(idx);
   endfunction

endpackage

/* sv/cbmt_csr.sv */
// APB-style configuration register file for the checkerboard test sequencer.
// Depends on cbmt_pkg for the register map, reset values and cfg_type.
`timescale 1ns / 1ps

module cbmt_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [cbmt_pkg::PADDR_BITS-1:0]   paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready,
   output cbmt_pkg::cfg_type                 cfg
);

   cbmt_pkg::cfg_type                      cfg_ff, cfg_in;
   logic [cbmt_pkg::REG_SEL_BITS-1:0]      reg_sel;
   logic                                   wr_en;

   assign pready  = 1'b1;
   assign reg_sel = paddr[cbmt_pkg::PADDR_BITS-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            cbmt_pkg::REG_BASE_WORD: begin
               cfg_in.base_word = pwdata[cbmt_pkg::ADDR_BITS-1:0];
            end
            cbmt_pkg::REG_WORD_COUNT: begin
               cfg_in.word_count = pwdata[cbmt_pkg::WC_BITS-1:0];
            end
            cbmt_pkg::REG_PATTERN_ONE: begin
               cfg_in.pattern_one = pwdata;
            end
            cbmt_pkg::REG_PATTERN_TWO: begin
               cfg_in.pattern_two = pwdata;
            end
            cbmt_pkg::REG_PATTERN_THREE: begin
               cfg_in.pattern_three = pwdata;
            end
            cbmt_pkg::REG_PATTERNS_USED: begin
               cfg_in.patterns_in_use = pwdata[1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         cbmt_pkg::REG_BASE_WORD:     prdata = 32'(cfg_ff.base_word);
         cbmt_pkg::REG_WORD_COUNT:    prdata = 32'(cfg_ff.word_count);
         cbmt_pkg::REG_PATTERN_ONE:   prdata = cfg_ff.pattern_one;
         cbmt_pkg::REG_PATTERN_TWO:   prdata = cfg_ff.pattern_two;
         cbmt_pkg::REG_PATTERN_THREE: prdata = cfg_ff.pattern_three;
         cbmt_pkg::REG_PATTERNS_USED: prdata = 32'(cfg_ff.patterns_in_use);
         default:                     prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_word       <= '0;
         cfg_ff.word_count      <= cbmt_pkg::WORD_COUNT_RST;
         cfg_ff.pattern_one     <= cbmt_pkg::PATTERN_ONE_RST;
         cfg_ff.pattern_two     <= cbmt_pkg::PATTERN_TWO_RST;
         cfg_ff.pattern_three   <= cbmt_pkg::PATTERN_THREE_RST;
         cfg_ff.patterns_in_use <= cbmt_pkg::PATTERNS_USED_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* sv/cbmt_step.sv */
// Single-step sequencing logic: from the current test state, the
// configuration and one request, forms the next state and the response.
// Depends on cbmt_pkg.
`timescale 1ns / 1ps

module cbmt_step (
   input  cbmt_pkg::cfg_type   cfg,
   input  cbmt_pkg::state_type state_cur,
   input  cbmt_pkg::req_type   req,
   output cbmt_pkg::state_type state_nxt,
   output cbmt_pkg::rsp_type   rsp
);

   logic [cbmt_pkg::CNT_BITS-1:0]   even_cnt, limit_cnt, n_cnt, n_m1;
   logic [cbmt_pkg::INDEX_BITS-1:0] last_idx;
   logic                            n_zero;
   logic [1:0]                      pat_count;
   logic                            done;
   cbmt_pkg::state_type             st, nx;
   cbmt_pkg::rsp_type               res;

   // words tested: count rounded down to even, saturated at the index range
   assign even_cnt  = cbmt_pkg::CNT_BITS'({cfg.word_count[cbmt_pkg::WC_BITS-1:1], 1'b0});
   assign limit_cnt = cbmt_pkg::CNT_BITS'(1) << cbmt_pkg::INDEX_BITS;
   assign n_cnt     = (even_cnt > limit_cnt) ? limit_cnt : even_cnt;
   assign n_zero    = (n_cnt == '0);
   assign n_m1      = n_cnt - cbmt_pkg::CNT_BITS'(1);
   assign last_idx  = n_m1[cbmt_pkg::INDEX_BITS-1:0];
   assign pat_count = (cfg.patterns_in_use == 2'd0) ? 2'd1 : cfg.patterns_in_use;

   assign st = (req.kind == cbmt_pkg::KIND_START) ? cbmt_pkg::STATE_START : state_cur;

   always_comb begin
      nx     = st;
      res    = '0;
      res.op = cbmt_pkg::OP_IDLE;
      done   = 1'b0;
      if (!st.running) begin
         done = 1'b1;
      end else if (n_zero) begin
         nx.running = 1'b0;
         res.op     = cbmt_pkg::OP_PASS;
         done       = 1'b1;
      end else begin
         if (st.compare_pending) begin
            nx.compare_pending = 1'b0;
            if (req.read_data != st.compare_value) begin
               nx.running        = 1'b0;
               res.op            = cbmt_pkg::OP_FAIL;
               res.address       = cbmt_pkg::word_addr(cfg.base_word, st.compare_index);
               res.fail_expected = st.compare_value;
               res.fail_actual   = req.read_data;
               res.fail_pattern  = st.pattern_index;
               done              = 1'b1;
            end else if (st.pass_number == cbmt_pkg::PASS_VERIFY) begin
               // write back the inverse of the word just checked
               res.op         = cbmt_pkg::OP_WRITE;
               res.address    = cbmt_pkg::word_addr(cfg.base_word, st.compare_index);
               res.write_data = ~st.compare_value;
               if (st.compare_index >= last_idx) begin
                  nx.pass_number = cbmt_pkg::PASS_FINAL;
                  nx.word_index  = '0;
               end else begin
                  nx.word_index = st.compare_index + cbmt_pkg::IDX_ONE;
               end
               done = 1'b1;
            end
         end
         if (!done && nx.pass_number == cbmt_pkg::PASS_DONE) begin
            nx.pattern_index = nx.pattern_index + 2'd1;
            if (nx.pattern_index >= pat_count) begin
               nx.running = 1'b0;
               res.op     = cbmt_pkg::OP_PASS;
               done       = 1'b1;
            end else begin
               nx.pass_number = cbmt_pkg::PASS_FILL;
               nx.word_index  = '0;
            end
         end
         if (!done) begin
            if (nx.pass_number == cbmt_pkg::PASS_FILL) begin
               res.op         = cbmt_pkg::OP_WRITE;
               res.address    = cbmt_pkg::word_addr(cfg.base_word, nx.word_index);
               res.write_data = cbmt_pkg::first_value(cfg, nx.pattern_index,
                                                      nx.word_index[0]);
               if (nx.word_index >= last_idx) begin
                  nx.pass_number = cbmt_pkg::PASS_VERIFY;
                  nx.word_index  = '0;
               end else begin
                  nx.word_index = nx.word_index + cbmt_pkg::IDX_ONE;
               end
            end else begin
               nx.compare_pending = 1'b1;
               nx.compare_index   = nx.word_index;
               res.op             = cbmt_pkg::OP_READ;
               res.address        = cbmt_pkg::word_addr(cfg.base_word, nx.word_index);
               if (nx.pass_number == cbmt_pkg::PASS_VERIFY) begin
                  nx.compare_value = cbmt_pkg::first_value(cfg, nx.pattern_index,
                                                           nx.word_index[0]);
               end else begin
                  nx.compare_value = ~cbmt_pkg::first_value(cfg, nx.pattern_index,
                                                            nx.word_index[0]);
                  if (nx.word_index >= last_idx) begin
                     nx.pass_number = cbmt_pkg::PASS_DONE;
                  end else begin
                     nx.word_index = nx.word_index + cbmt_pkg::IDX_ONE;
                  end
               end
            end
         end
      end
   end

   assign state_nxt = nx;
   assign rsp       = res;

endmodule

/* sv/checkerboard_memory_test_sequencer.sv */
// Top level of the checkerboard memory test sequencer: request register,
// test state, response register. Depends on cbmt_pkg, cbmt_csr, cbmt_step
// and checkerboard_memory_test_sequencer_defines.svh.
//
//   port group  direction  handshake                  payload
//   req_        in         req_valid / req_ready      req_payload (cbmt_pkg::req_type)
//   rsp_        out        rsp_valid / rsp_ready      rsp_payload (cbmt_pkg::rsp_type)
//   APB         in         psel, penable, pready      paddr, pwdata, prdata
//
// One request in and one response out per cycle while rsp_ready allows; a request
// passes the request register, then the step logic, then the response register.
// Sync active-high reset clears the test state to idle and loads register
// defaults. A stalled response stalls the request register; req_ready stays
// high while the request register is empty or moving on.
`timescale 1ns / 1ps

`include "checkerboard_memory_test_sequencer_defines.svh"

module checkerboard_memory_test_sequencer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  cbmt_pkg::req_type               req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output cbmt_pkg::rsp_type               rsp_payload,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [cbmt_pkg::PADDR_BITS-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);

   cbmt_pkg::cfg_type   cfg;
   logic                in_valid_ff, in_valid_in;
   cbmt_pkg::req_type   in_req_ff, in_req_in;
   logic                out_valid_ff, out_valid_in;
   cbmt_pkg::rsp_type   out_rsp_ff, out_rsp_in;
   cbmt_pkg::state_type state_ff, state_in;
   cbmt_pkg::state_type step_state;
   cbmt_pkg::rsp_type   step_rsp;
   logic                out_free, take_in, req_fire;

   cbmt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   cbmt_step u_step (
      .cfg       (cfg),
      .state_cur (state_ff),
      .req       (in_req_ff),
      .state_nxt (step_state),
      .rsp       (step_rsp)
   );

   assign out_free  = !out_valid_ff || rsp_ready;
   assign take_in   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      in_valid_in  = req_fire ? 1'b1 : (take_in ? 1'b0 : in_valid_ff);
      in_req_in    = req_fire ? req_payload : in_req_ff;
      out_valid_in = take_in ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
      out_rsp_in   = take_in ? step_rsp : out_rsp_ff;
      state_in     = take_in ? step_state : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= cbmt_pkg::STATE_RST;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_req_ff  <= in_req_in;
      out_rsp_ff <= out_rsp_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_rsp_ff;

   `CBMT_ASSERT_NEXT(a_step_lands, clock, reset, take_in, out_valid_ff)
   `CBMT_ASSERT_NOW(a_pending_pass, clock, reset, state_ff.compare_pending,
                    state_ff.pass_number != cbmt_pkg::PASS_FILL)
   `CBMT_ASSERT_NEXT(a_fail_stops, clock, reset,
                     take_in && step_rsp.op == cbmt_pkg::OP_FAIL, !state_ff.running)
   `CBMT_ASSERT_NOW(a_idle_addr_zero, clock, reset,
                    out_valid_ff && (out_rsp_ff.op == cbmt_pkg::OP_PASS ||
                                     out_rsp_ff.op == cbmt_pkg::OP_IDLE),
                    out_rsp_ff.address == '0)

endmodule
